// ===== hw/rtl/distance_matrix_double_centering_assert.svh =====
// Assertion macros for the double-centering block.
`ifndef DISTANCE_MATRIX_DOUBLE_CENTERING_ASSERT_SVH
`define DISTANCE_MATRIX_DOUBLE_CENTERING_ASSERT_SVH
`ifndef SYNTH
`define DMC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DMC_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMC_ASSERT(label, clk, rst_n, prop, msg)
`define DMC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/dmc_pkg.sv =====
// -----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the double-centering block.
// -----------------------------------------------------------------------------
`default_nettype none
package dmc_pkg;
  localparam int unsigned MaxN   = 64;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 40;
  localparam int unsigned OutW   = 42;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegModeU = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSize  = 1'b1;
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqFetch = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/dmc_if.sv =====
// -----------------------------------------------------------------------------
// dmc_req_if / dmc_rsp_if
// Valid/ready channels for requests and centered results.
// -----------------------------------------------------------------------------
`default_nettype none
interface dmc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] value;
  modport source (output valid, req_type, value, input ready);
  modport sink (input valid, req_type, value, output ready);
endinterface

interface dmc_rsp_if;
  logic        valid;
  logic        ready;
  logic [41:0] centered;
  logic [5:0]  row;
  logic [5:0]  col;
  logic        last;
  modport source (output valid, centered, row, col, last, input ready);
  modport sink (input valid, centered, row, col, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/distance_matrix_double_centering.sv =====
// -----------------------------------------------------------------------------
// distance_matrix_double_centering
// Stores an n-by-n distance matrix and emits its double-centered elements.
// -----------------------------------------------------------------------------
// channel   dir  payload
// req_i     in   req_type, value
// rsp_o     out  centered, row, col, last
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A load is a read-modify-write of the shared column-sum array; the first
// load of a matrix first clears the column sums. A fetch steps through SF1
// to SF4: the matrix element, mean[c] and mean[r] are read (the two means over
// the one column memory) and summed with the grand mean; the result waits in an
// output register. The last load adds a pass of one shared restoring divider
// over the columns, then over their sum. Reset clears control and config state and grand_q only.
`default_nettype none
`include "distance_matrix_double_centering_assert.svh"
module distance_matrix_double_centering (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [dmc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dmc_pkg::CfgW-1:0] cfg_data_i,
  dmc_req_if.sink   req_i,
  dmc_rsp_if.source rsp_o
);
  import dmc_pkg::*;
  localparam int unsigned NW = $clog2(MaxN);
  localparam int unsigned CW = NW + 1;

  localparam logic [3:0] SIdle = 4'd0, SLd = 4'd1, SClr = 4'd2, SDvRd = 4'd3,
    SDiv = 4'd4, SDvWr = 4'd5, SGDiv = 4'd6, SF1 = 4'd7, SF2 = 4'd8,
    SF3 = 4'd9, SF4 = 4'd10, SOut = 4'd11, SDvAd = 4'd12;

  logic [ValW-1:0] mat_mem [MaxN*MaxN];
  logic [SumW-1:0] col_mem [MaxN];
  logic [ValW-1:0] mat_rd_q;
  logic [SumW-1:0] col_rd_q;

  logic [3:0] st_q, st_d;
  logic mode_q;
  logic [CfgW-1:0] size_q;
  logic [NW-1:0] r_q, c_q, k_q;
  logic fetch_q;
  logic [OutW-1:0] grand_q, acc_q, quo_q, rem_q, gsum_q;
  logic [5:0] bit_q;
  logic [ValW-1:0] val_q;
  logic ovalid_q;
  logic [OutW-1:0] ocent_q;
  logic [IdxW-1:0] orow_q, ocol_q;
  logic olast_q;

  logic [CW-1:0] n_eff, d1, d2, dv;
  always_comb begin
    if (size_q < CfgW'(3)) n_eff = CW'(3);
    else if (size_q > CfgW'(MaxN)) n_eff = CW'(MaxN);
    else n_eff = CW'(size_q);
    d1 = mode_q ? n_eff - CW'(2) : n_eff;
    d2 = mode_q ? n_eff - CW'(1) : n_eff;
  end

  wire c_end = ({1'b0, c_q} + CW'(1)) == n_eff;
  wire r_end = ({1'b0, r_q} + CW'(1)) == n_eff;
  wire k_end = ({1'b0, k_q} + CW'(1)) == n_eff;
  wire acc_in = req_i.valid && req_i.ready;

  assign req_i.ready = (st_q == SIdle) && !ovalid_q;

  logic [NW-1:0] col_addr;
  always_comb begin
    case (st_q)
      SF1: col_addr = c_q;
      SF2: col_addr = r_q;
      SClr, SDvAd, SDvRd, SDvWr: col_addr = k_q;
      default: col_addr = c_q;
    endcase
  end

  // shared trial subtractor of the divider (column and grand-mean divisions)
  logic [OutW:0] trial;
  always_comb begin
    dv = (st_q == SGDiv) ? d2 : d1;
    trial = {1'b0, rem_q[OutW-2:0], quo_q[OutW-1]} - (OutW+1)'(dv);
  end

  logic col_we;
  logic [SumW-1:0] col_wd;
  always_comb begin
    col_we = 1'b0;
    col_wd = '0;
    case (st_q)
      SLd: begin
        col_we = 1'b1;
        col_wd = ((r_q == '0) ? '0 : col_rd_q) + SumW'(val_q);
      end
      SClr: begin
        col_we = 1'b1;
      end
      SDvWr: begin
        col_we = 1'b1;
        col_wd = quo_q[SumW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && req_i.req_type == ReqLoad && !fetch_q)
      mat_mem[{r_q, c_q}] <= req_i.value;
    mat_rd_q <= mat_mem[{r_q, c_q}];
    if (col_we) col_mem[col_addr] <= col_wd;
    col_rd_q <= col_mem[col_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      mode_q <= 1'b0;
      size_q <= CfgW'(64);
      r_q <= '0;
      c_q <= '0;
      k_q <= '0;
      fetch_q <= 1'b0;
      grand_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ovalid_q && rsp_o.ready) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegModeU) mode_q <= cfg_data_i[0];
        else if (cfg_idx_i == RegSize) size_q <= cfg_data_i;
        r_q <= '0;
        c_q <= '0;
        fetch_q <= 1'b0;
      end
      case (st_q)
        SIdle: if (acc_in && req_i.req_type == ReqLoad && !fetch_q) val_q <= req_i.value;
        SClr: k_q <= k_end ? '0 : k_q + NW'(1);
        SLd: begin
          k_q <= '0;
          if (!c_end) c_q <= c_q + NW'(1);
          else if (!r_end) begin
            c_q <= '0;
            r_q <= r_q + NW'(1);
          end
        end
        SDvWr: begin
          gsum_q <= gsum_q + OutW'(quo_q[SumW-1:0]);
          k_q <= k_end ? '0 : k_q + NW'(1);
          if (k_end) begin
            quo_q <= gsum_q + OutW'(quo_q[SumW-1:0]);
            rem_q <= '0;
            bit_q <= '0;
          end
        end
        SDvRd: begin
          quo_q <= OutW'(col_rd_q);
          rem_q <= '0;
          bit_q <= '0;
          if (k_q == '0) gsum_q <= '0;
        end
        SDiv, SGDiv: begin
          bit_q <= bit_q + 6'd1;
          if (!trial[OutW]) rem_q <= trial[OutW-1:0];
          else rem_q <= {rem_q[OutW-2:0], quo_q[OutW-1]};
          quo_q <= {quo_q[OutW-2:0], !trial[OutW]};
          if (st_q == SGDiv && bit_q == 6'(OutW-1)) begin
            grand_q <= {quo_q[OutW-2:0], !trial[OutW]};
            r_q <= '0;
            c_q <= '0;
            fetch_q <= 1'b1;
          end
        end
        SF2: acc_q <= OutW'(mat_rd_q) - OutW'(col_rd_q) + grand_q;
        SF3: acc_q <= acc_q - OutW'(col_rd_q);
        SF4: begin
          ovalid_q <= 1'b1;
          ocent_q <= (mode_q && r_q == c_q) ? '0 : acc_q;
          orow_q <= IdxW'(r_q);
          ocol_q <= IdxW'(c_q);
          olast_q <= r_end && c_end;
          if (r_end && c_end) begin
            r_q <= '0;
            c_q <= '0;
            fetch_q <= 1'b0;
          end else if (!c_end) c_q <= c_q + NW'(1);
          else begin
            c_q <= '0;
            r_q <= r_q + NW'(1);
          end
        end
        default: ;
      endcase
      if (st_q == SIdle && !cfg_we_i && ((r_q >= n_eff[NW-1:0] && n_eff != CW'(MaxN))
          || (c_q >= n_eff[NW-1:0] && n_eff != CW'(MaxN)))) begin
        r_q <= '0;
        c_q <= '0;
        fetch_q <= 1'b0;
      end
    end
  end

  wire first_ld = (r_q == '0) && (c_q == '0);
  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (acc_in) begin
        if (req_i.req_type == ReqLoad && !fetch_q) st_d = first_ld ? SClr : SLd;
        else if (req_i.req_type == ReqFetch && fetch_q) st_d = SF1;
      end
      SClr: if (k_end) st_d = SLd;
      SLd: st_d = (c_end && r_end) ? SDvAd : SIdle;
      SDvAd: st_d = SDvRd;
      SDvRd: st_d = SDiv;
      SDiv: if (bit_q == 6'(OutW-1)) st_d = SDvWr;
      SDvWr: st_d = k_end ? SGDiv : SDvAd;
      SGDiv: if (bit_q == 6'(OutW-1)) st_d = SIdle;
      SF1: st_d = SF2;
      SF2: st_d = SF3;
      SF3: st_d = SF4;
      SF4: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  assign rsp_o.valid = ovalid_q;
  assign rsp_o.centered = ocent_q;
  assign rsp_o.row = orow_q;
  assign rsp_o.col = ocol_q;
  assign rsp_o.last = olast_q;

  `DMC_ASSERT(a_no_accept_busy, clk_i, rst_ni, (st_q != SIdle) |-> !req_i.ready, "busy accept")
  `DMC_ASSERT(a_out_after_f4, clk_i, rst_ni, $rose(ovalid_q) |-> $past(st_q) == SF4, "spurious out")
  `DMC_ASSERT(a_fetch_phase, clk_i, rst_ni, (st_q == SF1) |-> fetch_q, "fetch outside phase")
endmodule
`default_nettype wire

// ===== sim/dmc_checker.sv =====
// -----------------------------------------------------------------------------
// dmc_checker
// Watches the request, result and register-write ports of the double-centering
// block, keeps its own copy of the stored matrix, column means and grand mean,
// and compares every result transfer with the oldest predicted element.
// -----------------------------------------------------------------------------
module dmc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dmc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dmc_pkg::CfgW-1:0]    cfg_data_i,
  dmc_req_if                          req,
  dmc_rsp_if                          rsp,
  output int                          errors,
  output int                          pending,
  output int                          delivered
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmc_pkg::*;

  typedef struct packed {
    logic [OutW-1:0] centered;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            last;
  } elem_t;

  elem_t           centered_q[$];
  logic [ValW-1:0] dist_mem[4096];
  logic [SumW-1:0] col_mean[64];
  logic [OutW-1:0] grand;
  int              row_pos, col_pos;
  bit              fetching;
  bit              mode_u;
  logic [CfgW-1:0] size_reg;

  function automatic int dim();
    if (size_reg < 3) return 3;
    if (size_reg > 64) return 64;
    return int'(size_reg);
  endfunction

  task automatic rewind();
    row_pos = 0;
    col_pos = 0;
    fetching = 0;
  endtask

  task automatic form_means(int n);
    longint unsigned d1, d2, total;
    d1 = mode_u ? n - 2 : n;
    d2 = mode_u ? n - 1 : n;
    total = 0;
    for (int i = 0; i < n; i++) begin
      col_mean[i] = SumW'(col_mean[i] / d1);
      total += col_mean[i];
    end
    grand = OutW'(total / d2);
  endtask

  task automatic predict(logic kind, logic [ValW-1:0] v);
    int n, r, c;
    longint s;
    elem_t e;
    n = dim();
    if (row_pos >= n || col_pos >= n) rewind();
    r = row_pos;
    c = col_pos;
    if (kind == ReqLoad) begin
      if (fetching) return;
      if (r == 0 && c == 0) foreach (col_mean[i]) col_mean[i] = '0;
      dist_mem[r*64 + c] = v;
      col_mean[c] = col_mean[c] + v;
      if (c + 1 < n) col_pos = c + 1;
      else if (r + 1 < n) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        form_means(n);
        rewind();
        fetching = 1;
      end
    end else begin
      if (!fetching) return;
      if (mode_u && r == c) s = 0;
      else s = longint'(dist_mem[r*64 + c]) - longint'(col_mean[c])
               - longint'(col_mean[r]) + longint'(grand);
      e.centered = s[OutW-1:0];
      e.row = IdxW'(r);
      e.col = IdxW'(c);
      e.last = (r + 1 == n) && (c + 1 == n);
      centered_q.push_back(e);
      if (e.last) rewind();
      else if (c + 1 < n) col_pos = c + 1;
      else begin
        col_pos = 0;
        row_pos = r + 1;
      end
    end
  endtask

  task automatic compare();
    elem_t e;
    if (centered_q.size() == 0) begin
      errors++;
      $display("%0t: result transfer with none expected: centered=%h row=%0d col=%0d",
               $time, rsp.centered, rsp.row, rsp.col);
      return;
    end
    e = centered_q.pop_front();
    if (rsp.centered !== e.centered) begin
      errors++;
      $display("%0t: centered expected %h actual %h", $time, e.centered, rsp.centered);
    end
    if (rsp.row !== e.row) begin
      errors++;
      $display("%0t: row expected %0d actual %0d", $time, e.row, rsp.row);
    end
    if (rsp.col !== e.col) begin
      errors++;
      $display("%0t: col expected %0d actual %0d", $time, e.col, rsp.col);
    end
    if (rsp.last !== e.last) begin
      errors++;
      $display("%0t: last expected %0b actual %0b", $time, e.last, rsp.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (col_mean[i]) col_mean[i] = '0;
      grand = '0;
      mode_u = 0;
      size_reg = 64;
      rewind();
      centered_q.delete();
      errors = 0;
      delivered = 0;
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegModeU: begin
            mode_u = cfg_data_i[0];
            rewind();
          end
          RegSize: begin
            size_reg = cfg_data_i;
            rewind();
          end
          default: ;
        endcase
      end
      if (req.valid && req.ready) predict(req.req_type, req.value);
      if (rsp.valid && rsp.ready) begin
        compare();
        delivered++;
      end
      pending = centered_q.size();
    end
  end
endmodule

// ===== sim/distance_matrix_double_centering_tb.sv =====
// -----------------------------------------------------------------------------
// distance_matrix_double_centering_tb
// Loads distance matrices of various sizes in V and U mode, fetches the
// centered elements and lets the checker compare them; both sides idle and
// stall at random, with one long result-side hold-off.
// -----------------------------------------------------------------------------
module distance_matrix_double_centering_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmc_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  int                 errors, pending, delivered;
  int                 sent;
  bit                 no_gaps;

  dmc_req_if req_if ();
  dmc_rsp_if rsp_if ();

  distance_matrix_double_centering uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req_i(req_if), .rsp_o(rsp_if)
  );

  dmc_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req_if), .rsp(rsp_if),
    .errors(errors), .pending(pending), .delivered(delivered)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int gap_len();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send(logic kind, logic [ValW-1:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.req_type = kind;
    req_if.value = v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] d);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // pattern: 0 random, 1 all ones, 2 all zero
  function automatic logic [ValW-1:0] dist_val(int pattern);
    int p;
    if (pattern == 1) return '1;
    if (pattern == 2) return '0;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return '1;
    if (p < 30) return $urandom_range(32'h0010_0000);
    return $urandom();
  endfunction

  task automatic run_matrix(bit mu, logic [CfgW-1:0] sz, int pattern,
                            int n_loads, int n_fetches);
    req_if.valid = 1'b0;
    wait (pending == 0);
    // block idle: no result waiting, no load or divider pass running
    @(negedge clk_i);
    while (!req_if.ready) @(negedge clk_i);
    write_reg(RegModeU, CfgW'(mu));
    write_reg(RegSize, sz);
    no_gaps = ($urandom_range(3) == 0);
    for (int i = 0; i < n_loads; i++) begin
      if ($urandom_range(19) == 0) send(ReqFetch, $urandom());
      send(ReqLoad, dist_val(pattern));
    end
    for (int i = 0; i < n_fetches; i++) begin
      if ($urandom_range(19) == 0) send(ReqLoad, $urandom());
      send(ReqFetch, $urandom());
    end
    if ($urandom_range(3) == 0) send(ReqFetch, $urandom());
    req_if.valid = 1'b0;
  endtask

  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && delivered >= 30) begin
        held = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready = 1'b0;
      end else if (no_gaps) rsp_if.ready = 1'b1;
      else if ($urandom_range(199) == 0) begin
        hold = $urandom_range(60, 15);
        rsp_if.ready = 1'b0;
      end else rsp_if.ready = ($urandom_range(99) < 70);
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n, sz, full;
    bit mu;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = ReqLoad;
    req_if.value = '0;
    sent = 0;
    no_gaps = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // fetch before any load is ignored
    send(ReqFetch, '0);
    req_if.valid = 1'b0;
    run_matrix(0, CfgW'(3), 1, 9, 9);
    run_matrix(1, CfgW'(3), 1, 9, 9);
    run_matrix(1, CfgW'(3), 2, 9, 9);
    run_matrix(0, CfgW'(0), 0, 9, 9);
    run_matrix(1, CfgW'(127), 0, 20, 0);
    run_matrix(1, CfgW'(4), 0, 16, 7);
    while (sent < 1750) begin
      mu = $urandom_range(1);
      full = $urandom_range(9);
      if (full == 0) sz = $urandom_range(2);
      else if (full == 1) sz = $urandom_range(20, 9);
      else sz = $urandom_range(8, 3);
      n = (sz < 3) ? 3 : sz;
      if ($urandom_range(9) == 0)
        run_matrix(mu, CfgW'(sz), 0, $urandom_range(n*n - 1, 1), 0);
      else if ($urandom_range(9) == 0)
        run_matrix(mu, CfgW'(sz), 0, n*n, $urandom_range(n*n - 1, 1));
      else run_matrix(mu, CfgW'(sz), 0, n*n, n*n);
    end
    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
